// File: hdl/start_time_fair_queue_scheduler_defines.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef START_TIME_FAIR_QUEUE_SCHEDULER_DEFINES_SVH
`define START_TIME_FAIR_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stfq checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define STFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stfq checker: next-cycle property failed");

`endif

// File: hdl/stfq_pkg.sv
// Package with constants, codes and types of the start-time fair queue scheduler.
package stfq_pkg;

    localparam int HEAP_SLOTS = 64;
    localparam int ADDR_W     = $clog2(HEAP_SLOTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int ID_W       = 16;
    localparam int TAG_W      = 31;
    localparam int OUT_W      = 7;
    localparam int INC_W      = 16;
    localparam int OP_W       = 2;

    localparam logic [INC_W-1:0] SVC_INC_RESET   = INC_W'(100);
    localparam logic [OUT_W-1:0] OUT_LIMIT_RESET = OUT_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_ARRIVE   = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic {
        REG_SVC_INC   = 1'b0,
        REG_OUT_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
    } heap_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        heap_entry_t       data;
    } heap_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } heap_rd_t;

    typedef struct packed {
        logic [TAG_W-1:0] vtime;
        logic [OUT_W-1:0] outstanding;
        logic [CNT_W-1:0] queued;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
        logic             granted;
        logic             accepted;
    } stfq_result_t;

endpackage

// File: hdl/stfq_heap_ram.sv
// Heap storage: one write port and two registered read ports.
module stfq_heap_ram
    import stfq_pkg::*;
(
    input  logic        aclk,
    input  heap_wr_t    wr,
    input  heap_rd_t    rd,
    output heap_entry_t rd_a,
    output heap_entry_t rd_b
);

    heap_entry_t mem [HEAP_SLOTS];
    heap_entry_t rd_a_reg;
    heap_entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_a_reg <= mem[rd.addr_a];
            rd_b_reg <= mem[rd.addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// File: hdl/stfq_ctrl.sv
// Sequencer: counters, virtual time, configuration and heap sift up and sift down.
module stfq_ctrl
    import stfq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ID_W-1:0]   in_id,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [INC_W-1:0]  cfg_wdata,
    output logic              res_valid,
    input  logic              res_ready,
    output stfq_result_t      res,
    output heap_wr_t          ram_wr,
    output heap_rd_t          ram_rd,
    input  heap_entry_t       rd_a,
    input  heap_entry_t       rd_b
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LAST   = 8'b0000_0010,
        S_UP_RD  = 8'b0000_0100,
        S_UP_CMP = 8'b0000_1000,
        S_POP    = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [OUT_W-1:0]   outst_reg, outst_next;
    logic [TAG_W-1:0]   vt_reg, vt_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    heap_entry_t        move_reg, move_next;
    logic               acc_reg, acc_next;
    logic               grant_reg, grant_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [TAG_W-1:0]   otag_reg, otag_next;
    logic [INC_W-1:0]   inc_reg;
    logic [OUT_W-1:0]   limit_reg;

    logic               in_fire;
    logic [TAG_W:0]     finish;
    logic [TAG_W-1:0]   finish_sat;
    logic [ADDR_W-1:0]  parent;
    logic [CNT_W-1:0]   left;
    logic [CNT_W:0]     right;
    logic               right_ok;
    logic               take_left;
    logic               take_right;
    logic [TAG_W-1:0]   best_tag;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);

    // Finish tag of the last slot, saturated to the tag range.
    assign finish     = {1'b0, rd_a.tag} + (TAG_W + 1)'(inc_reg);
    assign finish_sat = finish[TAG_W] ? {TAG_W{1'b1}} : finish[TAG_W-1:0];

    assign parent   = (pos_reg - ADDR_W'(1)) >> 1;
    assign left     = {pos_reg, 1'b1};
    assign right    = {1'b0, left} + (CNT_W + 1)'(1);
    assign right_ok = right < {1'b0, count_reg};

    // The left child is only read when it lies inside the heap.
    assign take_left  = rd_a.tag < move_reg.tag;
    assign best_tag   = take_left ? rd_a.tag : move_reg.tag;
    assign take_right = right_ok && (rd_b.tag < best_tag);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        outst_next = outst_reg;
        vt_next    = vt_reg;
        pos_next   = pos_reg;
        move_next  = move_reg;
        acc_next   = acc_reg;
        grant_next = grant_reg;
        oid_next   = oid_reg;
        otag_next  = otag_reg;
        ram_wr     = '0;
        ram_rd     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    acc_next   = 1'b0;
                    grant_next = 1'b0;
                    oid_next   = '0;
                    otag_next  = '0;
                    move_next  = '{tag: vt_reg, id: in_id};
                    state_next = S_DONE;
                    unique case (op_t'(in_op))
                        OP_ARRIVE: begin
                            if (count_reg == CNT_W'(HEAP_SLOTS)) begin
                                state_next = S_DONE;
                            end else if (count_reg != '0) begin
                                ram_rd.en     = 1'b1;
                                ram_rd.addr_a = ADDR_W'(count_reg - CNT_W'(1));
                                state_next    = S_LAST;
                            end else begin
                                pos_next   = '0;
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_DISPATCH: begin
                            if (count_reg != '0 && outst_reg <= limit_reg) begin
                                ram_rd.en     = 1'b1;
                                ram_rd.addr_a = '0;
                                ram_rd.addr_b = ADDR_W'(count_reg - CNT_W'(1));
                                state_next    = S_POP;
                            end
                        end
                        OP_COMPLETE: begin
                            if (outst_reg != '0) begin
                                outst_next = outst_reg - OUT_W'(1);
                            end
                        end
                        OP_NONE: begin
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LAST: begin
                if (finish_sat > vt_reg) begin
                    vt_next       = finish_sat;
                    move_next.tag = finish_sat;
                end
                pos_next   = ADDR_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = S_UP_RD;
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: move_reg};
                    acc_next   = 1'b1;
                    otag_next  = move_reg.tag;
                    state_next = S_DONE;
                end else begin
                    ram_rd.en     = 1'b1;
                    ram_rd.addr_a = parent;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (move_reg.tag < rd_a.tag) begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: rd_a};
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: move_reg};
                    acc_next   = 1'b1;
                    otag_next  = move_reg.tag;
                    state_next = S_DONE;
                end
            end
            S_POP: begin
                grant_next = 1'b1;
                oid_next   = rd_a.id;
                otag_next  = rd_a.tag;
                if (outst_reg != {OUT_W{1'b1}}) begin
                    outst_next = outst_reg + OUT_W'(1);
                end
                count_next = count_reg - CNT_W'(1);
                move_next  = rd_b;
                pos_next   = '0;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                if (left >= count_reg) begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: move_reg};
                    state_next = S_DONE;
                end else begin
                    ram_rd.en     = 1'b1;
                    ram_rd.addr_a = left[ADDR_W-1:0];
                    ram_rd.addr_b = right[ADDR_W-1:0];
                    state_next    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (take_right) begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: rd_b};
                    pos_next   = right[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end else if (take_left) begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: rd_a};
                    pos_next   = left[ADDR_W-1:0];
                    state_next = S_DN_RD;
                end else begin
                    ram_wr     = '{we: 1'b1, addr: pos_reg, data: move_reg};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            outst_reg <= '0;
            vt_reg    <= '0;
            inc_reg   <= SVC_INC_RESET;
            limit_reg <= OUT_LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            outst_reg <= outst_next;
            vt_reg    <= vt_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SVC_INC:   inc_reg   <= cfg_wdata;
                    REG_OUT_LIMIT: limit_reg <= cfg_wdata[OUT_W-1:0];
                    default:       inc_reg   <= inc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        move_reg  <= move_next;
        acc_reg   <= acc_next;
        grant_reg <= grant_next;
        oid_reg   <= oid_next;
        otag_reg  <= otag_next;
    end

    assign res = '{vtime:       vt_reg,
                   outstanding: outst_reg,
                   queued:      count_reg,
                   tag:         otag_reg,
                   id:          oid_reg,
                   granted:     grant_reg,
                   accepted:    acc_reg};

endmodule

// File: hdl/start_time_fair_queue_scheduler.sv
// Start-time fair queueing scheduler: a request heap ordered by start tag.
//
// Input channel s_*: one word per operation, the op code in s_tuser and the
// request handle in s_tdata. Arrivals are stamped with the virtual time and
// queued, dispatches pop the smallest start tag, completions lower the count
// of outstanding requests. Every accepted word gives exactly one result word
// on m_* with the flags, the handle and tag, and the counters after the step.
// A completion, an idle op, a refused dispatch or a dropped arrival goes
// straight to the result. An arrival into an empty heap is written at the
// root; any other arrival first reads the last slot for its finish tag, then
// climbs, reading and comparing one parent per level. A granted dispatch reads
// the root and the last slot, then sifts down, reading and comparing both
// children per level. The heap memory read is registered, so each level takes
// a read state and a compare state. One operation is in flight at a time: the
// input takes no new word until the last result has entered the output
// register, and takes the next word in the cycle after that. The output
// register holds a finished word while the next operation runs; when m_tready
// stays low the sequencer waits at the end of that operation.
// Reset (aresetn low, synchronous) empties the heap, clears the counters and
// virtual time and loads the service increment 100 and outstanding limit 64.
module start_time_fair_queue_scheduler
    import stfq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] request_id
    input  logic [1:0]        s_tuser,   // [1:0] op
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] accepted, [1] granted, [17:2] out_request_id, [48:18] out_start_tag,
    // [55:49] queued_count, [62:56] outstanding_count,
    // [93:63] current_virtual_time, [95:94] zero
    output logic [95:0]       m_tdata,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [INC_W-1:0]  cfg_wdata
);

    heap_wr_t      ram_wr;
    heap_rd_t      ram_rd;
    heap_entry_t   rd_a;
    heap_entry_t   rd_b;
    stfq_result_t  res;
    logic          res_valid;
    logic          res_ready;
    logic          m_tvalid_reg;
    logic [95:0]   m_tdata_reg;

    stfq_heap_ram u_ram (
        .aclk (aclk),
        .wr   (ram_wr),
        .rd   (ram_rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    stfq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_id     (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_wr    (ram_wr),
        .ram_rd    (ram_rd),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {2'b00, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hdl/stfq_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "start_time_fair_queue_scheduler_defines.svh"

module stfq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A stalled result word stays put.
    `STFQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An operation never both queues and dispatches.
    `STFQ_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tdata[0] && m_tdata[1]))

    // The handle is zero unless a request was handed out.
    `STFQ_ASSERT_NOW(a_id_zero, m_tvalid && !m_tdata[1], m_tdata[17:2] == 16'd0)

    // The heap never reports more entries than it has slots.
    `STFQ_ASSERT_NOW(a_queue_bound, m_tvalid, m_tdata[55:49] <= 7'd64)

endmodule

bind start_time_fair_queue_scheduler stfq_checker u_stfq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scheduler: stream driver, monitor and heap predictor.
module tb;
    import stfq_pkg::*;

    localparam logic [31:0] TAG_SAT   = 32'h7FFF_FFFF;
    localparam int          OUT_SAT   = (1 << OUT_W) - 1;
    localparam int          CLIMB_REP = 20;
    localparam int          HOLD_LEN  = 400;

    typedef struct packed {
        op_t        op;
        logic [15:0] rid;
    } sched_cmd_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [INC_W-1:0] cfg_wdata = '0;

    start_time_fair_queue_scheduler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted scheduler state.
    logic [TAG_W-1:0] pq_tag [HEAP_SLOTS];
    logic [ID_W-1:0]  pq_id  [HEAP_SLOTS];
    int               pq_count;
    int               pq_outst;
    logic [TAG_W-1:0] pq_vtime;
    logic [INC_W-1:0] pq_inc;
    logic [OUT_W-1:0] pq_limit;

    sched_cmd_t   pending_ops[$];
    stfq_result_t expected_words[$];

    int   err_count   = 0;
    int   n_accepted  = 0;
    int   n_results   = 0;
    logic in_fire     = 1'b0;
    logic out_fire    = 1'b0;
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;
    logic rx_hold     = 1'b0;
    int   tx_gap      = 0;
    int   rx_stall    = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        err_count++;
        if (err_count <= 50)
            $display("mismatch at result word %0d: %s got 0x%0h, expected 0x%0h",
                     n_results, field, got, want);
    endtask

    task automatic predict_sched_step(input op_t op, input logic [ID_W-1:0] rid,
                                      output stfq_result_t r);
        int pos, par, lft, rgt, best;
        logic [31:0] fin;
        logic [TAG_W-1:0] ttag;
        logic [ID_W-1:0] tid;
        bit done;
        r = '0;
        case (op)
            OP_ARRIVE: begin
                if (pq_count < HEAP_SLOTS) begin
                    if (pq_count > 0) begin
                        fin = {1'b0, pq_tag[pq_count-1]} + {16'd0, pq_inc};
                        if (fin > TAG_SAT)
                            fin = TAG_SAT;
                        if (fin[TAG_W-1:0] > pq_vtime)
                            pq_vtime = fin[TAG_W-1:0];
                    end
                    pos = pq_count;
                    pq_count++;
                    done = 0;
                    // A new entry climbs only past parents with strictly larger tags.
                    while (pos > 0 && !done) begin
                        par = (pos - 1) / 2;
                        if (pq_vtime < pq_tag[par]) begin
                            pq_tag[pos] = pq_tag[par];
                            pq_id[pos]  = pq_id[par];
                            pos = par;
                        end else begin
                            done = 1;
                        end
                    end
                    pq_tag[pos] = pq_vtime;
                    pq_id[pos]  = rid;
                    r.accepted = 1'b1;
                    r.tag      = pq_vtime;
                end
            end
            OP_DISPATCH: begin
                if (pq_count > 0 && pq_outst <= int'(pq_limit)) begin
                    if (pq_outst < OUT_SAT)
                        pq_outst++;
                    r.granted = 1'b1;
                    r.id      = pq_id[0];
                    r.tag     = pq_tag[0];
                    pq_count--;
                    pq_tag[0] = pq_tag[pq_count];
                    pq_id[0]  = pq_id[pq_count];
                    pos = 0;
                    done = 0;
                    // The left child wins a tie; a child moves up only if strictly smaller.
                    while (!done) begin
                        lft  = 2 * pos + 1;
                        rgt  = lft + 1;
                        best = pos;
                        if (lft < pq_count && pq_tag[lft] < pq_tag[best])
                            best = lft;
                        if (rgt < pq_count && pq_tag[rgt] < pq_tag[best])
                            best = rgt;
                        if (best == pos) begin
                            done = 1;
                        end else begin
                            ttag = pq_tag[pos];
                            tid  = pq_id[pos];
                            pq_tag[pos]  = pq_tag[best];
                            pq_id[pos]   = pq_id[best];
                            pq_tag[best] = ttag;
                            pq_id[best]  = tid;
                            pos = best;
                        end
                    end
                end
            end
            OP_COMPLETE: begin
                if (pq_outst > 0)
                    pq_outst--;
            end
            default: ;
        endcase
        r.queued      = CNT_W'(pq_count);
        r.outstanding = OUT_W'(pq_outst);
        r.vtime       = pq_vtime;
    endtask

    // Monitor: predicts on every accepted input word and checks every result word.
    always @(posedge aclk) begin : monitor
        stfq_result_t got, want;
        if (!aresetn) begin
            pq_count <= 0;
            pq_outst <= 0;
            pq_vtime <= '0;
            pq_inc   <= SVC_INC_RESET;
            pq_limit <= OUT_LIMIT_RESET;
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SVC_INC:   pq_inc   = cfg_wdata;
                    REG_OUT_LIMIT: pq_limit = cfg_wdata[OUT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = stfq_result_t'(m_tdata[93:0]);
                if (expected_words.size() == 0) begin
                    report_mismatch("word with no expectation waiting", m_tdata[63:0], 0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.granted !== want.granted)
                        report_mismatch("granted", got.granted, want.granted);
                    if (got.id !== want.id)
                        report_mismatch("out_request_id", got.id, want.id);
                    if (got.tag !== want.tag)
                        report_mismatch("out_start_tag", got.tag, want.tag);
                    if (got.queued !== want.queued)
                        report_mismatch("queued_count", got.queued, want.queued);
                    if (got.outstanding !== want.outstanding)
                        report_mismatch("outstanding_count", got.outstanding, want.outstanding);
                    if (got.vtime !== want.vtime)
                        report_mismatch("current_virtual_time", got.vtime, want.vtime);
                    if (m_tdata[95:94] !== 2'b00)
                        report_mismatch("padding bits", m_tdata[95:94], 0);
                end
                n_results++;
            end
            if (s_tvalid && s_tready) begin
                predict_sched_step(op_t'(s_tuser), s_tdata, want);
                expected_words.push_back(want);
                n_accepted++;
            end
        end
    end

    // Driver: offers queued words, with a random gap after each one while tx_idle_on is set.
    always @(negedge aclk) begin : driver
        sched_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (pending_ops.size() > 0) begin
                nxt = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.rid;
                tx_gap   <= tx_idle_on ? int'($urandom_range(0, 15)) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: may stall at random after each result word while rx_idle_on is set.
    always @(negedge aclk) begin : receiver
        int d;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (out_fire && rx_idle_on) begin
            d = $urandom_range(0, 15);
            m_tready <= (d == 0);
            rx_stall <= (d > 0) ? d - 1 : 0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long hold-off on the result side while the sender keeps offering words.
    initial begin
        wait (n_accepted >= 400);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #100_000_000;
        $display("** start_time_fair_queue_scheduler: FAILED **");
        $finish;
    end

    task automatic push_op(input op_t op, input logic [15:0] rid);
        sched_cmd_t c;
        c.op  = op;
        c.rid = rid;
        pending_ops.push_back(c);
    endtask

    task automatic wait_idle;
        do
            @(posedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_words.size() != 0);
    endtask

    task automatic set_config(input logic [INC_W-1:0] inc, input logic [OUT_W-1:0] lim);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SVC_INC;
        cfg_wdata <= inc;
        @(negedge aclk);
        cfg_index <= REG_OUT_LIMIT;
        cfg_wdata <= INC_W'(lim);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    task automatic queue_random(input int n, input int wa, input int wd, input int wc);
        int r;
        op_t op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < wa)
                op = OP_ARRIVE;
            else if (r < wa + wd)
                op = OP_DISPATCH;
            else if (r < wa + wd + wc)
                op = OP_COMPLETE;
            else
                op = OP_NONE;
            push_op(op, 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin : stimulus
        int drain_n;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words with the reset settings.
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_NONE,     16'hFFFF);
        push_op(OP_ARRIVE,   16'hFFFF);
        push_op(OP_ARRIVE,   16'h0000);
        push_op(OP_ARRIVE,   16'hAAAA);
        push_op(OP_ARRIVE,   16'h5555);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_ARRIVE,   16'h1234);
        push_op(OP_DISPATCH, 16'hFFFF);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_COMPLETE, 16'hFFFF);
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);

        // A zero limit refuses dispatch once one request is outstanding.
        set_config(16'd100, 7'd0);
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_ARRIVE,   16'h8001);
        push_op(OP_ARRIVE,   16'h7FFE);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);
        push_op(OP_COMPLETE, 16'h0000);
        push_op(OP_DISPATCH, 16'h0000);

        set_config(16'd100, 7'd64);
        queue_random(300, 40, 35, 20);
        // Arrival-heavy with a tight limit: the heap runs full and drops arrivals.
        set_config(16'd1, 7'd0);
        queue_random(200, 60, 25, 10);
        set_config(16'hFFFF, 7'd126);
        queue_random(200, 35, 35, 25);
        set_config(16'($urandom_range(1, 65535)), 7'($urandom_range(1, 10)));
        queue_random(150, 45, 40, 10);

        // Clear the outstanding count, then empty the heap.
        set_config(16'hFFFF, 7'd126);
        tx_idle_on = 0;
        rx_idle_on = 0;
        drain_n = pq_count;
        for (int i = 0; i < OUT_SAT; i++)
            push_op(OP_COMPLETE, 16'h0000);
        for (int i = 0; i < drain_n; i++)
            push_op(OP_DISPATCH, 16'h0000);

        // Drive the outstanding count to its ceiling, then back to zero.
        for (int i = 0; i < 130; i++) begin
            push_op(OP_ARRIVE, 16'($urandom_range(0, 65535)));
            push_op(OP_DISPATCH, 16'h0000);
        end
        for (int i = 0; i < 3; i++)
            push_op(OP_COMPLETE, 16'h0000);
        for (int i = 0; i < 3; i++)
            push_op(OP_DISPATCH, 16'h0000);
        for (int i = 0; i < OUT_SAT; i++)
            push_op(OP_COMPLETE, 16'h0000);

        // With one entry left in the heap each arrival raises virtual time by the
        // full increment.
        push_op(OP_ARRIVE, 16'($urandom_range(0, 65535)));
        for (int i = 0; i < CLIMB_REP; i++) begin
            push_op(OP_ARRIVE, 16'($urandom_range(0, 65535)));
            push_op(OP_DISPATCH, 16'h0000);
            push_op(OP_COMPLETE, 16'h0000);
        end
        wait_idle();
        tx_idle_on = 1;
        rx_idle_on = 1;
        // A mixed burst on top of the large tags left by the climb.
        queue_random(100, 55, 35, 8);

        set_config(16'($urandom_range(1, 65535)), 7'($urandom_range(0, 126)));
        queue_random(80, 40, 35, 20);

        wait_idle();
        repeat (64) @(posedge aclk);
        if (err_count == 0 && expected_words.size() == 0)
            $display("** start_time_fair_queue_scheduler: PASSED **");
        else
            $display("** start_time_fair_queue_scheduler: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/stfq_pkg.sv
hdl/stfq_heap_ram.sv
hdl/stfq_ctrl.sv
hdl/start_time_fair_queue_scheduler.sv
hdl/stfq_checker.sv
tb/tb.sv
